// ===== hw/rtl/rtp_mpeg4_generic_packetizer_assert.svh =====
// assertion helpers for the mpeg4-generic packetizer
// every use sits in a module that has i_clk and i_rst_n
`ifndef RTP_MPEG4_GENERIC_PACKETIZER_ASSERT_SVH
`define RTP_MPEG4_GENERIC_PACKETIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RMP4G_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RMP4G_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rmp4g_pkg.sv =====
package rmp4g_pkg;

    // field widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned SIZE_W     = 13;
    localparam int unsigned FRAME_W    = 12;
    localparam int unsigned OFFSET_W   = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // header sequencing: index 0..3 are au header bytes, HDR_DONE is the data byte
    localparam int unsigned HDR_IDX_W = 3;
    localparam logic [HDR_IDX_W-1:0] HDR_FIRST = 3'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_DONE  = 3'd4;

    // au header section bytes
    localparam logic [BYTE_W-1:0] AU_HDR_LEN_HI = 8'h00;
    localparam logic [BYTE_W-1:0] AU_HDR_LEN_LO = 8'h10;

    // rtp header plus au header section
    localparam logic [LEN_W-1:0] PKT_OVERHEAD = 16'd16;

    // register reset values
    localparam logic [LEN_W-1:0]   MTU_RESET   = 16'd1400;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 12'd0;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MTU       = 2'd0,
        CFG_FRAME_LEN = 2'd1
    } t_cfg_idx;

    // input operations
    typedef enum logic {
        OP_DATA         = 1'b0,
        OP_RESET_OFFSET = 1'b1
    } t_op;

endpackage

// ===== hw/rtl/rmp4g_in_if.sv =====
interface rmp4g_in_if;
    import rmp4g_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  unit_length;

    modport source (output valid, output operation, output data_byte,
                    output unit_length, input ready);
    modport sink   (input valid, input operation, input data_byte,
                    input unit_length, output ready);
endinterface

// ===== hw/rtl/rmp4g_out_if.sv =====
interface rmp4g_out_if;
    import rmp4g_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                is_header;
    logic                packet_start;
    logic                packet_end;
    logic                marker;
    logic                offset_valid;
    logic [OFFSET_W-1:0] packet_offset;
    logic                run_last;

    modport source (output valid, output out_byte, output is_header,
                    output packet_start, output packet_end, output marker,
                    output offset_valid, output packet_offset, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_header,
                    input packet_start, input packet_end, input marker,
                    input offset_valid, input packet_offset, input run_last,
                    output ready);
endinterface

// ===== hw/rtl/rmp4g_cfg_if.sv =====
interface rmp4g_cfg_if;
    import rmp4g_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rtp_mpeg4_generic_packetizer.sv =====
// RFC 3640 mpeg4-generic payload packetizer, one access unit byte per input
// transaction. A data byte that opens a packet produces five output
// transactions (the four AU header bytes, then the byte itself); every other
// data byte produces one transaction, and a reset-offset transaction
// produces none. The single result register presents one result per cycle
// while the output is ready; a new input transaction is taken in the same
// cycle the last result of the previous one is taken, so the data stream
// runs at one byte per cycle apart from the four header bytes per packet and
// output stalls. Packet state (unit and packet byte counts, marker, offset)
// is updated when the input transaction is accepted. Payloads carry at most
// mtu_bytes minus 16 data bytes (one when mtu_bytes is 16 or less); register
// writes are always accepted and take effect at the next packet start.
`include "rtp_mpeg4_generic_packetizer_assert.svh"

module rtp_mpeg4_generic_packetizer
    import rmp4g_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmp4g_in_if.sink    i_in,
    rmp4g_out_if.source o_out,
    rmp4g_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [LEN_W-1:0]   r_mtu;
    logic [FRAME_W-1:0] r_frame_len;

    // packet state
    logic [LEN_W-1:0]    r_unit_left,  n_unit_left;
    logic [LEN_W-1:0]    r_pkt_left,   n_pkt_left;
    logic [SIZE_W-1:0]   r_size,       n_size;
    logic                r_marker,     n_marker;
    logic [OFFSET_W-1:0] r_off_cnt,    n_off_cnt;
    logic [OFFSET_W-1:0] r_cur_off,    n_cur_off;
    logic                r_off_latch,  n_off_latch;

    // result register
    logic                 r_valid;
    logic [BYTE_W-1:0]    r_byte;
    logic                 r_end;
    logic [HDR_IDX_W-1:0] r_hdr_idx;

    logic in_take, out_take, res_last, data_take;
    logic [LEN_W-1:0] unit_len, pkt_left, chunk, pkt_size;
    logic             unit_new, pkt_new, mark_new;

    assign i_cfg.ready = 1'b1;

    // handshake
    assign res_last  = (r_hdr_idx == HDR_DONE);
    assign out_take  = o_out.valid && o_out.ready;
    assign i_in.ready = !r_valid || (out_take && res_last);
    assign in_take   = i_in.valid && i_in.ready;
    assign data_take = in_take && (i_in.operation == OP_DATA);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu       <= MTU_RESET;
            r_frame_len <= FRAME_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_MTU:       r_mtu       <= i_cfg.data;
                CFG_FRAME_LEN: r_frame_len <= i_cfg.data[FRAME_W-1:0];
                default:       ;
            endcase
        end
    end

    // packet state update for one accepted transaction
    always_comb begin
        n_unit_left = r_unit_left;
        n_pkt_left  = r_pkt_left;
        n_size      = r_size;
        n_marker    = r_marker;
        n_off_cnt   = r_off_cnt;
        n_cur_off   = r_cur_off;
        n_off_latch = r_off_latch;

        unit_new = (r_unit_left == '0);
        unit_len = unit_new ? ((i_in.unit_length == '0) ? LEN_W'(1) : i_in.unit_length)
                            : r_unit_left;
        pkt_left = unit_new ? '0 : r_pkt_left;
        pkt_new  = (pkt_left == '0);
        chunk    = (r_mtu > PKT_OVERHEAD) ? (r_mtu - PKT_OVERHEAD) : LEN_W'(1);
        mark_new = (unit_len <= chunk);
        pkt_size = pkt_new ? (mark_new ? unit_len : chunk) : pkt_left;

        if (in_take) begin
            if (i_in.operation == OP_RESET_OFFSET) begin
                n_off_cnt = '0;
            end else begin
                if (unit_new) begin
                    n_size = unit_len[SIZE_W-1:0];
                end
                if (pkt_new) begin
                    n_marker = mark_new;
                    if (r_frame_len != '0) begin
                        n_off_latch = 1'b1;
                        n_cur_off   = r_off_cnt;
                        n_off_cnt   = r_off_cnt + {{(OFFSET_W-FRAME_W){1'b0}}, r_frame_len};
                    end else begin
                        n_off_latch = 1'b0;
                        n_cur_off   = '0;
                    end
                end
                n_pkt_left  = pkt_size - LEN_W'(1);
                n_unit_left = unit_len - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_left <= '0;
            r_pkt_left  <= '0;
            r_size      <= '0;
            r_marker    <= 1'b0;
            r_off_cnt   <= '0;
            r_cur_off   <= '0;
            r_off_latch <= 1'b0;
        end else begin
            r_unit_left <= n_unit_left;
            r_pkt_left  <= n_pkt_left;
            r_size      <= n_size;
            r_marker    <= n_marker;
            r_off_cnt   <= n_off_cnt;
            r_cur_off   <= n_cur_off;
            r_off_latch <= n_off_latch;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_hdr_idx <= HDR_DONE;
        end else if (data_take) begin
            r_valid   <= 1'b1;
            r_hdr_idx <= pkt_new ? HDR_FIRST : HDR_DONE;
        end else if (out_take) begin
            if (res_last) begin
                r_valid <= 1'b0;
            end else begin
                r_hdr_idx <= r_hdr_idx + HDR_IDX_W'(1);
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (data_take) begin
            r_byte <= i_in.data_byte;
            r_end  <= (pkt_size == LEN_W'(1));
        end
    end

    // output selection: header bytes first, then the data byte
    always_comb begin
        case (r_hdr_idx)
            3'd0:    o_out.out_byte = AU_HDR_LEN_HI;
            3'd1:    o_out.out_byte = AU_HDR_LEN_LO;
            3'd2:    o_out.out_byte = r_size[SIZE_W-1:SIZE_W-BYTE_W];
            3'd3:    o_out.out_byte = {r_size[SIZE_W-BYTE_W-1:0], 3'b000};
            default: o_out.out_byte = r_byte;
        endcase
    end

    assign o_out.valid         = r_valid;
    assign o_out.is_header     = !res_last;
    assign o_out.packet_start  = (r_hdr_idx == HDR_FIRST);
    assign o_out.packet_end    = res_last && r_end;
    assign o_out.marker        = r_marker;
    assign o_out.offset_valid  = r_off_latch;
    assign o_out.packet_offset = r_off_latch ? r_cur_off : '0;
    assign o_out.run_last      = res_last;

    // checks
    `RMP4G_ASSERT_IMP(a_take_when_free, in_take, !r_valid || (out_take && res_last),
        "input taken while results still pending")
    `RMP4G_ASSERT_NXT(a_data_gives_result, data_take, r_valid,
        "data transaction produced no result")
    `RMP4G_ASSERT_IMP(a_unit_pkt_consistent, r_unit_left == '0, r_pkt_left == '0,
        "packet bytes left with no unit in progress")
    `RMP4G_ASSERT_IMP(a_header_not_end, r_valid && !res_last,
        !o_out.packet_end && !o_out.run_last, "header byte flagged as end")

endmodule

// ===== sim/rmp4g_packet_checker.sv =====
`timescale 1ns / 100ps

// watches the three channels, predicts every payload byte and compares
module rmp4g_packet_checker
    import rmp4g_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rmp4g_in_if  in_bus,
    rmp4g_out_if out_bus,
    rmp4g_cfg_if cfg_bus,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                is_header;
        logic                packet_start;
        logic                packet_end;
        logic                marker;
        logic                offset_valid;
        logic [OFFSET_W-1:0] packet_offset;
        logic                run_last;
    } t_payload_byte;

    // bytes still owed by the block, oldest first
    t_payload_byte payload_fifo[$];

    // register copies
    logic [LEN_W-1:0]    mtu_reg;
    logic [FRAME_W-1:0]  frame_reg;

    // packetizer state
    logic [LEN_W-1:0]    unit_left;
    logic [LEN_W-1:0]    pkt_left;
    logic [SIZE_W-1:0]   au_size;
    logic                pkt_marker;
    logic                stamp_on;
    logic [OFFSET_W-1:0] offset_acc;
    logic [OFFSET_W-1:0] pkt_offset;

    // queue one payload byte stamped with the current packet state
    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic hdr,
                              input logic first, input logic last_of_pkt,
                              input logic last_of_run);
        t_payload_byte pb;
        pb.out_byte      = b;
        pb.is_header     = hdr;
        pb.packet_start  = first;
        pb.packet_end    = last_of_pkt;
        pb.marker        = pkt_marker;
        pb.offset_valid  = stamp_on;
        pb.packet_offset = stamp_on ? pkt_offset : '0;
        pb.run_last      = last_of_run;
        payload_fifo.push_back(pb);
    endtask

    // advance the packetizer by one accepted input transaction
    task automatic packetize(input logic op, input logic [BYTE_W-1:0] b,
                             input logic [LEN_W-1:0] tag);
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] chunk;
        if (op == OP_RESET_OFFSET) begin
            offset_acc = '0;
        end else begin
            // unit length only counts on the first byte of a unit
            if (unit_left == '0) begin
                len       = (tag == '0) ? 16'd1 : tag;
                unit_left = len;
                au_size   = len[SIZE_W-1:0];
                pkt_left  = '0;
            end
            // new packet: cut size, marker, offset stamp, au header section
            if (pkt_left == '0) begin
                chunk      = (mtu_reg > PKT_OVERHEAD) ? mtu_reg - PKT_OVERHEAD : 16'd1;
                pkt_marker = (unit_left <= chunk);
                pkt_left   = pkt_marker ? unit_left : chunk;
                if (frame_reg != '0) begin
                    stamp_on   = 1'b1;
                    pkt_offset = offset_acc;
                    offset_acc = offset_acc + OFFSET_W'(frame_reg);
                end else begin
                    stamp_on   = 1'b0;
                    pkt_offset = '0;
                end
                queue_byte(AU_HDR_LEN_HI, 1'b1, 1'b1, 1'b0, 1'b0);
                queue_byte(AU_HDR_LEN_LO, 1'b1, 1'b0, 1'b0, 1'b0);
                queue_byte(au_size[12:5], 1'b1, 1'b0, 1'b0, 1'b0);
                queue_byte({au_size[4:0], 3'b000}, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            pkt_left  = pkt_left - 16'd1;
            unit_left = unit_left - 16'd1;
            queue_byte(b, 1'b0, 1'b0, pkt_left == '0, 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [OFFSET_W-1:0] want,
                               input logic [OFFSET_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_payload_byte want;
        if (!i_rst_n) begin
            payload_fifo.delete();
            mtu_reg    = MTU_RESET;
            frame_reg  = FRAME_RESET;
            unit_left  = '0;
            pkt_left   = '0;
            au_size    = '0;
            pkt_marker = 1'b0;
            stamp_on   = 1'b0;
            offset_acc = '0;
            pkt_offset = '0;
        end else begin
            // output transaction against the oldest expectation
            if (out_bus.valid && out_bus.ready) begin
                if (payload_fifo.size() == 0) begin
                    $display("%0t: unexpected output, expected none, actual byte 0x%0h",
                             $time, out_bus.out_byte);
                    o_errors++;
                end else begin
                    want = payload_fifo.pop_front();
                    check_field("out_byte", OFFSET_W'(want.out_byte),
                                OFFSET_W'(out_bus.out_byte));
                    check_field("is_header", OFFSET_W'(want.is_header),
                                OFFSET_W'(out_bus.is_header));
                    check_field("packet_start", OFFSET_W'(want.packet_start),
                                OFFSET_W'(out_bus.packet_start));
                    check_field("packet_end", OFFSET_W'(want.packet_end),
                                OFFSET_W'(out_bus.packet_end));
                    check_field("marker", OFFSET_W'(want.marker),
                                OFFSET_W'(out_bus.marker));
                    check_field("offset_valid", OFFSET_W'(want.offset_valid),
                                OFFSET_W'(out_bus.offset_valid));
                    check_field("packet_offset", want.packet_offset, out_bus.packet_offset);
                    check_field("run_last", OFFSET_W'(want.run_last),
                                OFFSET_W'(out_bus.run_last));
                end
            end
            // register write
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_MTU:       mtu_reg = cfg_bus.data;
                    CFG_FRAME_LEN: frame_reg = cfg_bus.data[FRAME_W-1:0];
                    default: ;
                endcase
            end
            // input transaction
            if (in_bus.valid && in_bus.ready) begin
                packetize(in_bus.operation, in_bus.data_byte, in_bus.unit_length);
            end
        end
        o_pending = payload_fifo.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rmp4g_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE_GAP   = 4;

    logic i_clk;
    logic i_rst_n;

    rmp4g_in_if  in_bus();
    rmp4g_out_if out_bus();
    rmp4g_cfg_if cfg_bus();

    int   fail_count;
    int   bytes_owed;
    int   items_sent;
    int   cycle_count;
    logic src_idling;
    logic sink_idling;
    logic hold_request;

    // access unit currently being streamed
    int               unit_left;
    logic [LEN_W-1:0] unit_len;

    rtp_mpeg4_generic_packetizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    rmp4g_packet_checker packet_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_bus    (in_bus),
        .out_bus   (out_bus),
        .cfg_bus   (cfg_bus),
        .o_errors  (fail_count),
        .o_pending (bytes_owed)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: random stall bursts, plus one long hold on request
    initial begin : sink_drive
        int   gap_left;
        int   hold_left;
        logic hold_seen;
        gap_left      = 0;
        hold_left     = 0;
        hold_seen     = 1'b0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                out_bus.ready <= 1'b0;
            end else if (sink_idling && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(0, 7);
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // offer one input transaction, called at a falling edge
    task automatic push_item(input t_op op, input logic [BYTE_W-1:0] b,
                             input logic [LEN_W-1:0] tag);
        if (src_idling && $urandom_range(0, 3) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.operation   <= op;
        in_bus.data_byte   <= b;
        in_bus.unit_length <= tag;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // stop offering and wait until every expected byte has come out
    task automatic settle_output();
        in_bus.valid <= 1'b0;
        while (bytes_owed != 0) @(negedge i_clk);
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    // write both registers, only while the block is idle
    task automatic configure(input logic [LEN_W-1:0] mtu, input logic [FRAME_W-1:0] frame);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_MTU;
        cfg_bus.data  <= mtu;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.index <= CFG_FRAME_LEN;
        cfg_bus.data  <= CFG_DATA_W'(frame);
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // next byte of a random access unit stream, with offset resets and noisy tags
    task automatic stream_byte();
        logic [LEN_W-1:0] tag;
        if ($urandom_range(0, 11) == 0)
            push_item(OP_RESET_OFFSET, BYTE_W'($urandom_range(0, 255)),
                      LEN_W'($urandom_range(0, 65535)));
        if (unit_left == 0) begin
            case ($urandom_range(0, 15))
                0:       unit_len = '0;
                1:       unit_len = LEN_W'($urandom_range(41, 120));
                default: unit_len = LEN_W'($urandom_range(1, 40));
            endcase
            unit_left = (unit_len == '0) ? 1 : int'(unit_len);
            tag       = unit_len;
        end else if ($urandom_range(0, 7) == 0) begin
            tag = LEN_W'($urandom_range(0, 65535));
        end else begin
            tag = unit_len;
        end
        push_item(OP_DATA, BYTE_W'($urandom_range(0, 255)), tag);
        unit_left--;
    endtask

    initial begin : stimulus
        int phase;
        int run_len;
        logic [LEN_W-1:0]   mtu;
        logic [FRAME_W-1:0] frame;

        // every input known from time zero
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.operation   = OP_DATA;
        in_bus.data_byte   = '0;
        in_bus.unit_length = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_MTU;
        cfg_bus.data       = '0;
        items_sent         = 0;
        src_idling         = 1'b1;
        sink_idling        = 1'b1;
        hold_request       = 1'b0;
        unit_left          = 0;
        unit_len           = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: zero length unit, one byte unit, offset reset
        push_item(OP_DATA, 8'hFF, 16'h0000);
        push_item(OP_DATA, 8'h00, 16'h0001);
        push_item(OP_RESET_OFFSET, 8'hA5, 16'hFFFF);
        settle_output();

        // tiny mtu: one byte per packet, offset stamped at full frame length
        configure(16'd16, 12'd4095);
        push_item(OP_DATA, 8'h5A, 16'd3);
        push_item(OP_RESET_OFFSET, 8'h00, 16'h0000);
        push_item(OP_DATA, 8'hC3, 16'hFFFF);
        push_item(OP_DATA, 8'h3C, 16'h0000);
        push_item(OP_DATA, 8'h81, 16'h0000);
        settle_output();

        // random phases, each with its own register setting
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle_output();
            case (phase % 6)
                0:       mtu = 16'd32;
                1:       mtu = 16'hFFFF;
                2:       mtu = LEN_W'($urandom_range(33, 60));
                3:       mtu = 16'd17;
                4:       mtu = 16'd16;
                default: mtu = LEN_W'($urandom_range(32, 1500));
            endcase
            case (phase % 4)
                0:       frame = '0;
                1:       frame = 12'hFFF;
                2:       frame = 12'd1;
                default: frame = FRAME_W'($urandom_range(2, 4094));
            endcase
            configure(mtu, frame);
            src_idling  = ($urandom_range(0, 2) != 0);
            sink_idling = ($urandom_range(0, 2) != 0);
            if (phase == 2)
                hold_request = 1'b1;
            run_len = $urandom_range(30, 70);
            repeat (run_len) stream_byte();
            phase++;
        end

        // last part without idling: close the open unit, then a long unit
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        while (unit_left > 0) stream_byte();
        settle_output();
        configure(16'd32, 12'd4095);
        repeat (22) push_item(OP_DATA, BYTE_W'($urandom_range(0, 255)), 16'hFFFF);

        settle_output();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
